FILE: hdl/bsc_pkg.sv
// ---------------------------------------------------------------------------
// Banker's safety checker package
// Shared payload types, action and status codes, and the cell command set.
// ---------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

  localparam int DEF_MAX_PROCS  = 16;
  localparam int DEF_MAX_RES    = 8;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic [4:0] PROC_CNT_RST = 5'd16;
  localparam logic [3:0] RES_CNT_RST  = 4'd8;

  localparam logic CFG_PROC_CNT = 1'b0;
  localparam logic CFG_RES_CNT  = 1'b1;

  localparam logic [1:0] ACT_SET_TOTAL = 2'd0;
  localparam logic [1:0] ACT_LOAD      = 2'd1;
  localparam logic [1:0] ACT_REQUEST   = 2'd2;
  localparam logic [1:0] ACT_CHECK     = 2'd3;

  localparam logic [2:0] STAT_STORED   = 3'd0;
  localparam logic [2:0] STAT_INVALID  = 3'd1;
  localparam logic [2:0] STAT_GRANTED  = 3'd2;
  localparam logic [2:0] STAT_EXCEEDS  = 3'd3;
  localparam logic [2:0] STAT_REFUSED  = 3'd4;
  localparam logic [2:0] STAT_SAFE     = 3'd5;
  localparam logic [2:0] STAT_UNSAFE   = 3'd6;

  localparam logic KIND_SEQ    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  proc_index;
    logic [2:0]  res_index;
    logic [15:0] amount;
    logic [15:0] max_claim;
    logic        final_element;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [3:0] seq_process;
    logic [2:0] status;
    logic       last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_GRANT,
    OP_ROLLBACK,
    OP_CLEAR
  } cell_op_t;

  // Token that walks the cell row during a safety pass.
  typedef struct packed {
    logic valid;
    logic progress;
  } link_t;

endpackage

`default_nettype wire

FILE: hdl/bsc_cell.sv
// ---------------------------------------------------------------------------
// Banker's safety checker process cell
// Holds one process row of allocation and need, and evaluates that process
// when the pass token reaches it.
// ---------------------------------------------------------------------------
`default_nettype none

module bsc_cell import bsc_pkg::*; #(
  parameter int IDX        = 0,
  parameter int MAX_RES    = DEF_MAX_RES,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int PIDX_W     = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire cell_op_t                              cmd_op,
  input  wire logic [PIDX_W-1:0]                     cmd_proc,
  input  wire logic [MAX_RES-1:0]                    res_sel,
  input  wire logic [MAX_RES-1:0]                    res_en,
  input  wire logic [COUNT_BITS-1:0]                 cmd_amt,
  input  wire logic [COUNT_BITS-1:0]                 cmd_need,
  input  wire logic [MAX_RES-1:0][COUNT_BITS-1:0]    pend,
  input  wire logic [4:0]                            np,
  input  wire link_t                                 link_in,
  input  wire logic [MAX_RES-1:0][COUNT_BITS-1:0]    work_in,
  output link_t                                      link_out,
  output logic [MAX_RES-1:0][COUNT_BITS-1:0]         work_out,
  output logic                                       fin_pulse,
  output logic [MAX_RES-1:0][COUNT_BITS-1:0]         alloc_row,
  output logic [MAX_RES-1:0][COUNT_BITS-1:0]         need_row
);

  logic [MAX_RES-1:0][COUNT_BITS-1:0] alloc_r, alloc_nxt;
  logic [MAX_RES-1:0][COUNT_BITS-1:0] need_r, need_nxt;
  logic [MAX_RES-1:0][COUNT_BITS-1:0] work_r, work_nxt;
  logic  fin_r, fin_nxt;
  logic  pulse_r, pulse_nxt;
  link_t tok_r, tok_nxt;
  logic  hit, active, fits, take;

  always_comb begin
    hit    = (cmd_proc == PIDX_W'(IDX));
    active = (IDX < np);
    fits   = 1'b1;
    for (int k = 0; k < MAX_RES; k++) begin
      if (res_en[k] && (need_r[k] > work_in[k])) fits = 1'b0;
    end
    take = link_in.valid && active && !fin_r && fits;

    alloc_nxt = alloc_r;
    need_nxt  = need_r;
    fin_nxt   = take ? 1'b1 : fin_r;
    case (cmd_op)
      OP_LOAD: begin
        for (int k = 0; k < MAX_RES; k++) begin
          if (hit && res_sel[k]) begin
            alloc_nxt[k] = cmd_amt;
            need_nxt[k]  = cmd_need;
          end
        end
      end
      OP_GRANT: begin
        for (int k = 0; k < MAX_RES; k++) begin
          if (hit && res_en[k]) begin
            alloc_nxt[k] = alloc_r[k] + pend[k];
            need_nxt[k]  = need_r[k] - pend[k];
          end
        end
      end
      OP_ROLLBACK: begin
        for (int k = 0; k < MAX_RES; k++) begin
          if (hit && res_en[k]) begin
            alloc_nxt[k] = alloc_r[k] - pend[k];
            need_nxt[k]  = need_r[k] + pend[k];
          end
        end
      end
      OP_CLEAR: fin_nxt = 1'b0;
      default: ;
    endcase

    tok_nxt.valid    = link_in.valid;
    tok_nxt.progress = link_in.valid && (link_in.progress || take);
    pulse_nxt        = take;
    for (int k = 0; k < MAX_RES; k++) begin
      work_nxt[k] = work_in[k] + ((take && res_en[k]) ? alloc_r[k] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
      need_r  <= '0;
      fin_r   <= 1'b0;
      pulse_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      alloc_r <= alloc_nxt;
      need_r  <= need_nxt;
      fin_r   <= fin_nxt;
      pulse_r <= pulse_nxt;
      tok_r   <= tok_nxt;
    end
    work_r <= work_nxt;
  end

  assign link_out  = tok_r;
  assign work_out  = work_r;
  assign fin_pulse = pulse_r;
  assign alloc_row = alloc_r;
  assign need_row  = need_r;

endmodule

`default_nettype wire

FILE: hdl/bankers_safety_checker_core.sv
// Timing: loads and set-total pass from acceptance through an execute state to
// their status transfer. A safety check runs passes along the cell row, repeated
// while any process finishes (up to MAX_PROCS + 1 passes). The safe order is
// emitted after it, before the status transfer.
// Flow: one item at a time; the cell row pass sets the evaluation time.
// Reset: synchronous, active low; allocation, need, total, available and pending tables clear to zero at once.
// ---------------------------------------------------------------------------
// Banker's safety checker core
// Deadlock-avoidance engine: keeps allocation, need, totals and available
// units, grants requests tentatively and proves them safe on a row of cells.
// ---------------------------------------------------------------------------
`default_nettype none

module bankers_safety_checker_core import bsc_pkg::*; #(
  parameter int MAX_PROCS  = DEF_MAX_PROCS,
  parameter int MAX_RES    = DEF_MAX_RES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [4:0] cfg_wdata
);

  localparam int PIDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int CB     = COUNT_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_CHECK, S_START, S_RUN, S_EMIT, S_STATUS
  } state_t;

  state_t    state_r, state_nxt;
  in_item_t  item_r, item_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic [4:0] proc_cnt_r;
  logic [3:0] res_cnt_r;

  logic [MAX_RES-1:0][CB-1:0] total_r, total_nxt;
  logic [MAX_RES-1:0][CB-1:0] avail_r, avail_nxt;
  logic [MAX_RES-1:0][CB-1:0] pend_r, pend_nxt;

  // Token injected into the first cell at the start of each pass.
  link_t                      inj_r, inj_nxt;
  logic [MAX_RES-1:0][CB-1:0] inj_work_r, inj_work_nxt;

  logic [CNT_W-1:0]  fin_cnt_r, fin_cnt_nxt, cnt_eff;
  logic [CNT_W-1:0]  emit_idx_r, emit_idx_nxt;
  logic [PIDX_W-1:0] seq_mem [MAX_PROCS];
  logic              seq_we;
  logic [PIDX_W-1:0] fin_idx;
  logic              fin_any;

  // Cell row interconnect.
  link_t                              lnk [MAX_PROCS+1];
  logic [MAX_PROCS:0][MAX_RES-1:0][CB-1:0]   wk;
  logic [MAX_PROCS-1:0][MAX_RES-1:0][CB-1:0] alloc_rows, need_rows;
  logic [MAX_PROCS-1:0]               fin_pulse;
  logic [MAX_PROCS:0]                 tok_vec;

  cell_op_t          cmd_op;
  logic [PIDX_W-1:0] cmd_proc;
  logic [CB-1:0]     amt, clm, cmd_need;
  logic [4:0]        np;
  logic [3:0]        nr;
  logic [MAX_RES-1:0] res_sel, res_en;
  logic [CB-1:0]     tot_sel, av_sel, alloc_sel;
  logic [MAX_RES-1:0][CB-1:0] need_sel;
  logic              r_ok, p_ok, slot_free, req_fail;

  // Effective counts: zero reads as one, oversize reads as the table size.
  always_comb begin
    if (proc_cnt_r == 5'd0)           np = 5'd1;
    else if (proc_cnt_r > MAX_PROCS)  np = 5'(MAX_PROCS);
    else                              np = proc_cnt_r;
    if (res_cnt_r == 4'd0)            nr = 4'd1;
    else if (res_cnt_r > MAX_RES)     nr = 4'(MAX_RES);
    else                              nr = res_cnt_r;
  end

  // Operand selection for the item in hand. The column sum of allocations is
  // never stored: it always equals total minus available.
  always_comb begin
    amt       = CB'(item_r.amount);
    clm       = CB'(item_r.max_claim);
    cmd_need  = clm - amt;
    cmd_proc  = PIDX_W'(item_r.proc_index);
    r_ok      = ({1'b0, item_r.res_index} < nr);
    p_ok      = ({1'b0, item_r.proc_index} < np);
    tot_sel   = '0;
    av_sel    = '0;
    alloc_sel = '0;
    need_sel  = '0;
    for (int k = 0; k < MAX_RES; k++) begin
      res_sel[k] = (k == item_r.res_index);
      res_en[k]  = (k < nr);
      if (res_sel[k]) begin
        tot_sel = tot_sel | total_r[k];
        av_sel  = av_sel | avail_r[k];
      end
    end
    for (int p = 0; p < MAX_PROCS; p++) begin
      if (p == item_r.proc_index) begin
        need_sel = need_sel | need_rows[p];
        for (int k = 0; k < MAX_RES; k++) begin
          if (res_sel[k]) alloc_sel = alloc_sel | alloc_rows[p][k];
        end
      end
    end
    req_fail = 1'b0;
    for (int k = 0; k < MAX_RES; k++) begin
      if (res_en[k] && ((pend_r[k] > need_sel[k]) || (pend_r[k] > avail_r[k]))) begin
        req_fail = 1'b1;
      end
    end
  end

  // Only one cell holds the token, so at most one finish pulse per cycle.
  always_comb begin
    fin_any = 1'b0;
    fin_idx = '0;
    for (int p = 0; p < MAX_PROCS; p++) begin
      if (fin_pulse[p]) begin
        fin_any = 1'b1;
        fin_idx = PIDX_W'(p);
      end
    end
    cnt_eff = fin_cnt_r + CNT_W'(fin_any);
  end

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    stat_nxt      = stat_r;
    total_nxt     = total_r;
    avail_nxt     = avail_r;
    pend_nxt      = pend_r;
    inj_nxt       = inj_r;
    inj_work_nxt  = inj_work_r;
    fin_cnt_nxt   = fin_cnt_r;
    emit_idx_nxt  = emit_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd_op        = OP_NONE;
    seq_we        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_STATUS;
        stat_nxt  = STAT_INVALID;
        case (item_r.action)
          ACT_SET_TOTAL: begin
            if (r_ok && (amt >= tot_sel - av_sel)) begin
              stat_nxt = STAT_STORED;
              for (int k = 0; k < MAX_RES; k++) begin
                if (res_sel[k]) begin
                  total_nxt[k] = amt;
                  avail_nxt[k] = amt - (tot_sel - av_sel);
                end
              end
            end
          end
          ACT_LOAD: begin
            if (p_ok && r_ok && (amt <= clm) &&
                ({1'b0, amt} <= {1'b0, av_sel} + {1'b0, alloc_sel})) begin
              stat_nxt = STAT_STORED;
              cmd_op   = OP_LOAD;
              for (int k = 0; k < MAX_RES; k++) begin
                if (res_sel[k]) avail_nxt[k] = av_sel + alloc_sel - amt;
              end
            end
          end
          ACT_REQUEST: begin
            if (r_ok && !(item_r.final_element && !p_ok)) begin
              stat_nxt = STAT_STORED;
              for (int k = 0; k < MAX_RES; k++) begin
                if (res_sel[k]) pend_nxt[k] = amt;
              end
              if (item_r.final_element) state_nxt = S_CHECK;
            end
          end
          default: state_nxt = S_START;
        endcase
      end

      S_CHECK: begin
        if (req_fail) begin
          stat_nxt  = STAT_EXCEEDS;
          state_nxt = S_STATUS;
        end else begin
          cmd_op = OP_GRANT;
          for (int k = 0; k < MAX_RES; k++) begin
            if (res_en[k]) avail_nxt[k] = avail_r[k] - pend_r[k];
          end
          state_nxt = S_START;
        end
      end

      S_START: begin
        cmd_op           = OP_CLEAR;
        inj_nxt.valid    = 1'b1;
        inj_nxt.progress = 1'b0;
        inj_work_nxt     = avail_r;
        fin_cnt_nxt      = '0;
        state_nxt        = S_RUN;
      end

      S_RUN: begin
        inj_nxt.valid = 1'b0;
        if (fin_any) begin
          seq_we      = 1'b1;
          fin_cnt_nxt = cnt_eff;
        end
        if (lnk[MAX_PROCS].valid) begin
          if (lnk[MAX_PROCS].progress) begin
            // Someone finished: run another pass with the grown work vector.
            inj_nxt.valid    = 1'b1;
            inj_nxt.progress = 1'b0;
            inj_work_nxt     = wk[MAX_PROCS];
          end else if (cnt_eff == np) begin
            stat_nxt     = (item_r.action == ACT_REQUEST) ? STAT_GRANTED : STAT_SAFE;
            emit_idx_nxt = '0;
            state_nxt    = S_EMIT;
          end else begin
            if (item_r.action == ACT_REQUEST) begin
              cmd_op   = OP_ROLLBACK;
              stat_nxt = STAT_REFUSED;
              for (int k = 0; k < MAX_RES; k++) begin
                if (res_en[k]) avail_nxt[k] = avail_r[k] + pend_r[k];
              end
            end else begin
              stat_nxt = STAT_UNSAFE;
            end
            state_nxt = S_STATUS;
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = KIND_SEQ;
          out_data_nxt.seq_process = 4'(seq_mem[emit_idx_r[PIDX_W-1:0]]);
          out_data_nxt.status      = STAT_STORED;
          out_data_nxt.last_of_run = 1'b0;
          emit_idx_nxt             = emit_idx_r + 1'b1;
          if (emit_idx_nxt == fin_cnt_r) state_nxt = S_STATUS;
        end
      end

      S_STATUS: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = KIND_STATUS;
          out_data_nxt.seq_process = 4'd0;
          out_data_nxt.status      = stat_r;
          out_data_nxt.last_of_run = 1'b1;
          state_nxt                = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      proc_cnt_r  <= PROC_CNT_RST;
      res_cnt_r   <= RES_CNT_RST;
      total_r     <= '0;
      avail_r     <= '0;
      pend_r      <= '0;
      inj_r       <= '0;
      fin_cnt_r   <= '0;
      emit_idx_r  <= '0;
      stat_r      <= STAT_STORED;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      avail_r     <= avail_nxt;
      pend_r      <= pend_nxt;
      inj_r       <= inj_nxt;
      fin_cnt_r   <= fin_cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      stat_r      <= stat_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_PROC_CNT) proc_cnt_r <= cfg_wdata;
        else                           res_cnt_r  <= cfg_wdata[3:0];
      end
    end
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
    inj_work_r <= inj_work_nxt;
  end

  // Finishing order, one entry per finished process.
  always_ff @(posedge clk) begin
    if (seq_we) seq_mem[fin_cnt_r[PIDX_W-1:0]] <= fin_idx;
  end

  assign lnk[0] = inj_r;
  assign wk[0]  = inj_work_r;

  for (genvar p = 0; p < MAX_PROCS; p++) begin : g_cell
    bsc_cell #(
      .IDX        (p),
      .MAX_RES    (MAX_RES),
      .COUNT_BITS (COUNT_BITS),
      .PIDX_W     (PIDX_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd_op    (cmd_op),
      .cmd_proc  (cmd_proc),
      .res_sel   (res_sel),
      .res_en    (res_en),
      .cmd_amt   (amt),
      .cmd_need  (cmd_need),
      .pend      (pend_r),
      .np        (np),
      .link_in   (lnk[p]),
      .work_in   (wk[p]),
      .link_out  (lnk[p+1]),
      .work_out  (wk[p+1]),
      .fin_pulse (fin_pulse[p]),
      .alloc_row (alloc_rows[p]),
      .need_row  (need_rows[p])
    );
  end

  always_comb begin
    for (int p = 0; p <= MAX_PROCS; p++) tok_vec[p] = lnk[p].valid;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The pass token is never duplicated along the row.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec)) else $error("more than one pass token in the cell row");

  // At most one finish pulse at a time, and only during a safety pass.
  a_pulse_tok: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(fin_pulse) && ((fin_pulse == '0) || (state_r == S_RUN)))
    else $error("finish pulse outside a safety pass");

  // The safe order is emitted only when every process in use finished.
  a_emit_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (fin_cnt_r == np)) else $error("partial safe order");

  // Each status transfer ends the run of its item.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STATUS) && slot_free |=> out_valid && out_data.last_of_run)
    else $error("status item without run end");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Banker's safety checker testbench
// Drives totals, loads, request elements and safety checks through the core,
// predicts every result transfer with a behavioral model of the algorithm and
// compares each one field by field in arrival order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import bsc_pkg::*;

  localparam int NPROC = DEF_MAX_PROCS;
  localparam int NRES  = DEF_MAX_RES;
  localparam int IDLE_PCT = 29;
  localparam int STALL_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_index = 1'b0;
  logic [4:0] cfg_wdata = '0;

  bankers_safety_checker_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of the bank tables and the registers.
  logic [15:0] bank_alloc [NPROC][NRES];
  logic [15:0] bank_need  [NPROC][NRES];
  logic [15:0] bank_total [NRES];
  logic [15:0] bank_avail [NRES];
  logic [15:0] bank_pend  [NRES];
  logic [4:0]  reg_procs;
  logic [3:0]  reg_res;
  int          finish_order [NPROC];

  out_item_t expected_results [$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;   // When set, neither side idles.

  function automatic int procs_in_use();
    if (reg_procs == 0) return 1;
    if (reg_procs > NPROC) return NPROC;
    return reg_procs;
  endfunction

  function automatic int res_in_use();
    if (reg_res == 0) return 1;
    if (reg_res > NRES) return NRES;
    return reg_res;
  endfunction

  // Column sums cover every row, including processes beyond the active count.
  function automatic logic [31:0] units_held(int r);
    logic [31:0] s;
    s = 0;
    for (int p = 0; p < NPROC; p++) s += bank_alloc[p][r];
    return s;
  endfunction

  function automatic void refresh_avail(int r);
    logic [31:0] s;
    s = units_held(r);
    bank_avail[r] = (bank_total[r] >= s) ? 16'(bank_total[r] - s) : 16'd0;
  endfunction

  // Repeated passes over the processes while any one finishes; returns how
  // many finished and leaves their order in finish_order.
  function automatic int run_safety();
    logic [31:0] work [NRES];
    bit done [NPROC];
    int np, nr, n;
    bit moved, fits;
    np = procs_in_use();
    nr = res_in_use();
    n = 0;
    for (int r = 0; r < NRES; r++) work[r] = bank_avail[r];
    for (int p = 0; p < NPROC; p++) done[p] = 0;
    moved = 1;
    while (moved) begin
      moved = 0;
      for (int p = 0; p < np; p++) begin
        if (done[p]) continue;
        fits = 1;
        for (int r = 0; r < nr; r++)
          if (bank_need[p][r] > work[r]) fits = 0;
        if (!fits) continue;
        done[p] = 1;
        finish_order[n++] = p;
        for (int r = 0; r < nr; r++) work[r] += bank_alloc[p][r];
        moved = 1;
      end
    end
    return n;
  endfunction

  function automatic void push_status(logic [2:0] st);
    out_item_t o;
    o = '0;
    o.kind = KIND_STATUS;
    o.status = st;
    o.last_of_run = 1'b1;
    expected_results = {expected_results, o};
  endfunction

  function automatic void push_order(int n);
    out_item_t o;
    for (int i = 0; i < n; i++) begin
      o = '0;
      o.kind = KIND_SEQ;
      o.seq_process = 4'(finish_order[i]);
      expected_results = {expected_results, o};
    end
  endfunction

  // Works out the result transfers of one accepted input transfer.
  function automatic void predict_banker(in_item_t it);
    int p, r, np, nr, n;
    logic [31:0] others;
    bit over;
    p = it.proc_index;
    r = it.res_index;
    np = procs_in_use();
    nr = res_in_use();
    case (it.action)
      ACT_SET_TOTAL: begin
        if (r >= nr || it.amount < units_held(r)) push_status(STAT_INVALID);
        else begin
          bank_total[r] = it.amount;
          refresh_avail(r);
          push_status(STAT_STORED);
        end
      end
      ACT_LOAD: begin
        if (p >= np || r >= nr || it.amount > it.max_claim) push_status(STAT_INVALID);
        else begin
          others = units_held(r) - bank_alloc[p][r];
          if (others + it.amount > bank_total[r]) push_status(STAT_INVALID);
          else begin
            bank_alloc[p][r] = it.amount;
            bank_need[p][r] = it.max_claim - it.amount;
            refresh_avail(r);
            push_status(STAT_STORED);
          end
        end
      end
      ACT_REQUEST: begin
        if (r >= nr || (it.final_element && p >= np)) push_status(STAT_INVALID);
        else begin
          bank_pend[r] = it.amount;
          if (!it.final_element) push_status(STAT_STORED);
          else begin
            over = 0;
            for (int k = 0; k < nr; k++)
              if (bank_pend[k] > bank_need[p][k] || bank_pend[k] > bank_avail[k])
                over = 1;
            if (over) push_status(STAT_EXCEEDS);
            else begin
              for (int k = 0; k < nr; k++) begin
                bank_avail[k] -= bank_pend[k];
                bank_alloc[p][k] += bank_pend[k];
                bank_need[p][k] -= bank_pend[k];
              end
              n = run_safety();
              if (n != np) begin
                // Unsafe: the tentative grant is rolled back.
                for (int k = 0; k < nr; k++) begin
                  bank_avail[k] += bank_pend[k];
                  bank_alloc[p][k] -= bank_pend[k];
                  bank_need[p][k] += bank_pend[k];
                end
                push_status(STAT_REFUSED);
              end else begin
                push_order(n);
                push_status(STAT_GRANTED);
              end
            end
          end
        end
      end
      default: begin
        n = run_safety();
        if (n != np) push_status(STAT_UNSAFE);
        else begin
          push_order(n);
          push_status(STAT_SAFE);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Result side: random stalls, comparison against the oldest expectation.
  always @(negedge clk) begin
    if (rst_n) out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer, status", out_data.status, -1);
      end else begin
        want = expected_results.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch("kind", out_data.kind, want.kind);
        if (out_data.seq_process !== want.seq_process)
          report_mismatch("seq_process", out_data.seq_process, want.seq_process);
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", out_data.last_of_run, want.last_of_run);
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Sends one item. Valid goes up at a falling edge and stays up until the
  // transfer; the expected results are computed at the accepting edge. Valid
  // is left up afterward so that a following item can go back to back; it is
  // dropped by an idle cycle or by drop_input.
  task automatic send_item(in_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_banker(it);
    @(negedge clk);
  endtask

  // Ends the input stream at the current falling edge.
  task automatic drop_input();
    in_valid <= 1'b0;
  endtask

  // Register writes only while the core is idle; the settle delay covers the
  // worst-case safety check after the last status transfer.
  task automatic write_reg(logic idx, logic [4:0] val);
    drop_input();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PROC_CNT) reg_procs = val;
    else reg_res = val[3:0];
  endtask

  function automatic in_item_t make_item(logic [1:0] act, int p, int r, int amt,
                                         int claim, bit fin);
    in_item_t it;
    it.action = act;
    it.proc_index = 4'(p);
    it.res_index = 3'(r);
    it.amount = 16'(amt);
    it.max_claim = 16'(claim);
    it.final_element = fin;
    return it;
  endfunction

  // Random item biased toward well-formed traffic in the active ranges.
  function automatic in_item_t random_item();
    int np, nr, roll, p, r;
    np = procs_in_use();
    nr = res_in_use();
    roll = $urandom_range(99);
    p = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(np - 1);
    r = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(nr - 1);
    if (roll < 10)
      return make_item(ACT_SET_TOTAL, $urandom_range(15), r,
                       ($urandom_range(7) == 0) ? $urandom_range(65535)
                                                : $urandom_range(40), 0, 0);
    if (roll < 40)
      return make_item(ACT_LOAD, p, r, $urandom_range(6), $urandom_range(12),
                       $urandom_range(1));
    if (roll < 85)
      return make_item(ACT_REQUEST, p, r, ($urandom_range(19) == 0) ?
                       $urandom_range(65535) : $urandom_range(3), $urandom_range(65535),
                       $urandom_range(2) == 0);
    return make_item(ACT_CHECK, p, r, $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(1));
  endfunction

  // Directed rows: fixed expectations where obvious, predictor elsewhere.
  typedef struct {
    in_item_t   item;
    bit         typed;
    logic [2:0] want;
  } plan_row_t;

  plan_row_t plan [$];

  task automatic add_row(in_item_t it, bit typed, logic [2:0] want);
    plan_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    plan = {plan, row};
  endtask

  initial begin
    int tail_idx;
    for (int p = 0; p < NPROC; p++)
      for (int r = 0; r < NRES; r++) begin
        bank_alloc[p][r] = 0;
        bank_need[p][r] = 0;
      end
    for (int r = 0; r < NRES; r++) begin
      bank_total[r] = 0;
      bank_avail[r] = 0;
      bank_pend[r] = 0;
    end
    reg_procs = PROC_CNT_RST;
    reg_res = RES_CNT_RST;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Right after reset everything is empty: all needs are zero, so safe.
    add_row(make_item(ACT_CHECK, 0, 0, 0, 0, 0), 1, STAT_SAFE);
    add_row(make_item(ACT_SET_TOTAL, 0, 0, 16'hFFFF, 0, 0), 1, STAT_STORED);
    add_row(make_item(ACT_SET_TOTAL, 0, 7, 0, 0, 0), 1, STAT_STORED);
    add_row(make_item(ACT_LOAD, 15, 0, 16'hFFFF, 16'hFFFF, 1), 1, STAT_STORED);
    add_row(make_item(ACT_SET_TOTAL, 0, 0, 100, 0, 0), 1, STAT_INVALID);
    add_row(make_item(ACT_LOAD, 3, 1, 5, 4, 0), 1, STAT_INVALID);
    add_row(make_item(ACT_LOAD, 3, 7, 1, 2, 0), 1, STAT_INVALID);
    add_row(make_item(ACT_LOAD, 15, 0, 0, 3, 0), 1, STAT_STORED);
    add_row(make_item(ACT_SET_TOTAL, 0, 1, 10, 0, 0), 1, STAT_STORED);
    add_row(make_item(ACT_LOAD, 0, 1, 4, 9, 0), 1, STAT_STORED);
    add_row(make_item(ACT_LOAD, 1, 1, 6, 8, 0), 1, STAT_STORED);
    add_row(make_item(ACT_REQUEST, 0, 0, 16'hFFFF, 0, 0), 0, 0);
    add_row(make_item(ACT_REQUEST, 0, 0, 0, 0, 0), 0, 0);
    add_row(make_item(ACT_REQUEST, 0, 1, 0, 0, 1), 0, 0);
    add_row(make_item(ACT_CHECK, 0, 0, 0, 0, 0), 0, 0);
    add_row(make_item(ACT_REQUEST, 1, 1, 9, 0, 1), 1, STAT_EXCEEDS);
    add_row(make_item(ACT_REQUEST, 1, 1, 0, 0, 1), 0, 0);
    add_row(make_item(ACT_LOAD, 2, 1, 0, 16'hFFFF, 0), 1, STAT_STORED);
    add_row(make_item(ACT_CHECK, 0, 0, 0, 0, 0), 1, STAT_UNSAFE);
    add_row(make_item(ACT_LOAD, 2, 1, 0, 0, 0), 1, STAT_STORED);
    add_row(make_item(ACT_LOAD, 1, 1, 6, 16'hFFFF, 0), 1, STAT_STORED);
    add_row(make_item(ACT_REQUEST, 0, 1, 0, 0, 1), 1, STAT_REFUSED);
    add_row(make_item(ACT_LOAD, 1, 1, 6, 8, 0), 1, STAT_STORED);

    foreach (plan[i]) begin
      send_item(plan[i].item);
      if (plan[i].typed) begin
        // A typed row sets the status that closes its run.
        tail_idx = expected_results.size() - 1;
        expected_results[tail_idx].status = plan[i].want;
      end
    end

    // Requests and a load with out-of-range indexes under a reduced setting.
    write_reg(CFG_PROC_CNT, 5'd3);
    write_reg(CFG_RES_CNT, 4'd2);
    send_item(make_item(ACT_REQUEST, 15, 1, 0, 0, 1));
    send_item(make_item(ACT_REQUEST, 0, 5, 0, 0, 1));
    send_item(make_item(ACT_LOAD, 4, 0, 0, 0, 0));

    // Random phases across several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_PROC_CNT, 5'd16); write_reg(CFG_RES_CNT, 4'd8); end
        1: begin write_reg(CFG_PROC_CNT, 5'd1);  write_reg(CFG_RES_CNT, 4'd1); end
        2: begin write_reg(CFG_PROC_CNT, 5'd0);  write_reg(CFG_RES_CNT, 4'd0); end
        3: begin write_reg(CFG_PROC_CNT, 5'd31); write_reg(CFG_RES_CNT, 4'd15); end
        4: begin write_reg(CFG_PROC_CNT, 5'd4);  write_reg(CFG_RES_CNT, 4'd3); end
        default: begin write_reg(CFG_PROC_CNT, 5'd7); write_reg(CFG_RES_CNT, 4'd5); end
      endcase
      calm = (ph == 4);
      for (int i = 0; i < 21; i++) send_item(random_item());
      calm = 1'b0;
    end

    drop_input();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
